[rtl/cgrg_pkg.sv]
package cgrg_pkg;

    localparam int unsigned DOTS_W = 11;
    localparam int unsigned CNT_W  = 16;
    localparam int unsigned HDR_W  = 7;
    localparam int unsigned BPL_W  = 8;

    localparam logic [HDR_W-1:0]  PREAMBLE_ESCAPES = 7'd100;
    localparam logic [DOTS_W-1:0] MAX_HEAD         = 11'd2040;
    localparam logic [DOTS_W-1:0] BORDER_DOTS      = 11'd4;
    localparam logic [CNT_W-1:0]  BORDER_LINES     = 16'd4;
    localparam logic [CNT_W-1:0]  RULE_WIDTH       = 16'd3;

    localparam logic [7:0] ESC_BYTE   = 8'h1B;
    localparam logic [7:0] SYN_BYTE   = 8'h16;
    localparam logic [7:0] CMD_INIT   = 8'h40;
    localparam logic [7:0] CMD_LENGTH = 8'h4C;
    localparam logic [7:0] CMD_BPL    = 8'h44;
    localparam logic [7:0] CMD_END    = 8'h45;
    localparam logic [7:0] SOLID_BYTE = 8'hFF;

    typedef struct packed {
        logic clear;
        logic start;
    } t_ser_ctl;

    typedef struct packed {
        logic       done;
        logic [7:0] data;
    } t_ser_stat;

    function automatic logic [CNT_W-1:0] step_mod(input logic [CNT_W-1:0] c,
                                                  input logic [CNT_W-1:0] m);
        logic [CNT_W:0] n;
        n = {1'b0, c} + {{CNT_W{1'b0}}, 1'b1};
        return (n >= {1'b0, m}) ? '0 : n[CNT_W-1:0];
    endfunction

endpackage

[rtl/cgrg_bitser.sv]
module cgrg_bitser (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  cgrg_pkg::t_ser_ctl           i_ctl,
    input  logic [cgrg_pkg::DOTS_W-1:0]  i_dots,
    input  logic [cgrg_pkg::CNT_W-1:0]   i_minor,
    input  logic [cgrg_pkg::CNT_W-1:0]   i_major,
    output cgrg_pkg::t_ser_stat          o_stat
);

    logic [cgrg_pkg::DOTS_W-1:0] r_col;
    logic [cgrg_pkg::CNT_W-1:0]  r_mmin;
    logic [cgrg_pkg::CNT_W-1:0]  r_mmaj;
    logic [7:0]                  r_shift;
    logic [2:0]                  r_cnt;
    logic                        r_run;
    logic                        r_done;
    logic                        w_bit;

    assign w_bit = (r_col < i_dots) &&
                   ((r_col < cgrg_pkg::BORDER_DOTS) || (r_mmin == '0) ||
                    (r_mmaj < cgrg_pkg::RULE_WIDTH));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_ctl.start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd7) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.clear) begin
            r_col  <= '0;
            r_mmin <= '0;
            r_mmaj <= '0;
        end else if (r_run) begin
            r_shift <= {r_shift[6:0], w_bit};
            r_col   <= r_col + {{(cgrg_pkg::DOTS_W-1){1'b0}}, 1'b1};
            r_mmin  <= cgrg_pkg::step_mod(r_mmin, i_minor);
            r_mmaj  <= cgrg_pkg::step_mod(r_mmaj, i_major);
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.data = r_shift;

endmodule

[rtl/calibration_grid_raster_gen.sv]
// Calibration grid job generator. Each accepted request returns at most one beat: start_req
// high restarts the job (or returns one error beat if the configuration is invalid), low
// returns the next job byte, and nothing while no job runs. Header, SYN, solid and trailer
// bytes pass through the generate and put states into the output register (an error beat skips
// the generate state); a non-solid pattern byte also waits in the serialise state while its eight
// columns are evaluated one bit per cycle by the column serialiser, which steps both rule counters
// once per bit. Requests are stalled from acceptance until the result is loaded into the output
// register, so a request can be taken while the previous beat still waits downstream. Configuration
// is latched at start.
module calibration_grid_raster_gen (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_start_req,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [7:0]  o_data_byte,
    output logic        o_last,
    output logic        o_error,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [15:0] i_cfg_data
);

    localparam logic [2:0] REG_HEAD_DOTS  = 3'd0;
    localparam logic [2:0] REG_LINE_COUNT = 3'd1;
    localparam logic [2:0] REG_MAX_LINES  = 3'd2;
    localparam logic [2:0] REG_MINOR      = 3'd3;
    localparam logic [2:0] REG_MAJOR      = 3'd4;

    localparam logic [1:0] C_WAIT = 2'd0;
    localparam logic [1:0] C_GEN  = 2'd1;
    localparam logic [1:0] C_SER  = 2'd2;
    localparam logic [1:0] C_PUT  = 2'd3;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_PRE   = 3'd1;
    localparam logic [2:0] PH_HDR   = 3'd2;
    localparam logic [2:0] PH_SYNC  = 3'd3;
    localparam logic [2:0] PH_LINE  = 3'd4;
    localparam logic [2:0] PH_TAIL0 = 3'd5;
    localparam logic [2:0] PH_TAIL1 = 3'd6;

    localparam logic [6:0] HDR_INIT    = 7'd1;
    localparam logic [6:0] HDR_LENGTH  = 7'd3;
    localparam logic [6:0] HDR_LEN_HI  = 7'd4;
    localparam logic [6:0] HDR_LEN_LO  = 7'd5;
    localparam logic [6:0] HDR_BPL_CMD = 7'd7;
    localparam logic [6:0] HDR_BPL     = 7'd8;

    logic [cgrg_pkg::DOTS_W-1:0] r_cfg_dots;
    logic [cgrg_pkg::CNT_W-1:0]  r_cfg_lines;
    logic [cgrg_pkg::CNT_W-1:0]  r_cfg_max;
    logic [cgrg_pkg::CNT_W-1:0]  r_cfg_minor;
    logic [cgrg_pkg::CNT_W-1:0]  r_cfg_major;

    logic [cgrg_pkg::DOTS_W-1:0] r_j_dots;
    logic [cgrg_pkg::CNT_W-1:0]  r_j_lines;
    logic [cgrg_pkg::BPL_W-1:0]  r_j_bpl;
    logic [cgrg_pkg::CNT_W-1:0]  r_j_minor;
    logic [cgrg_pkg::CNT_W-1:0]  r_j_major;

    logic [1:0]                  r_ctl;
    logic [2:0]                  r_phase;
    logic [cgrg_pkg::HDR_W-1:0]  r_hdr;
    logic [cgrg_pkg::CNT_W-1:0]  r_line;
    logic [cgrg_pkg::BPL_W-1:0]  r_bidx;
    logic [cgrg_pkg::CNT_W-1:0]  r_lmin;
    logic [cgrg_pkg::CNT_W-1:0]  r_lmaj;
    logic                        r_solid;

    logic [7:0]                  r_res_byte;
    logic                        r_res_last;
    logic                        r_res_err;
    logic                        r_out_valid;
    logic [7:0]                  r_out_byte;
    logic                        r_out_last;
    logic                        r_out_err;

    logic                        w_in_acc;
    logic                        w_cfg_bad;
    logic [cgrg_pkg::DOTS_W-1:0] w_dots_clip;
    logic [cgrg_pkg::DOTS_W:0]   w_dots_sum;
    logic [cgrg_pkg::CNT_W:0]    w_line_inc;
    logic                        w_line_end;
    logic [cgrg_pkg::BPL_W:0]    w_bidx_inc;
    logic                        w_out_free;
    logic [7:0]                  w_hdr_byte;

    cgrg_pkg::t_ser_ctl          s_ctl;
    cgrg_pkg::t_ser_stat         s_stat;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_ctl != C_WAIT);
    assign w_in_acc    = i_in_valid && !o_in_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    assign w_cfg_bad = (r_cfg_lines == '0) || (r_cfg_lines > r_cfg_max) ||
                       (r_cfg_minor == '0) || (r_cfg_major == '0);
    assign w_dots_clip = (r_cfg_dots > cgrg_pkg::MAX_HEAD) ? cgrg_pkg::MAX_HEAD : r_cfg_dots;
    assign w_dots_sum  = {1'b0, w_dots_clip} + 12'd7;

    assign w_line_inc = {1'b0, r_line} + 17'd1;
    assign w_line_end = (w_line_inc >= {1'b0, r_j_lines});
    assign w_bidx_inc = {1'b0, r_bidx} + 9'd1;

    always_comb begin
        case (r_hdr)
            HDR_INIT:    w_hdr_byte = cgrg_pkg::CMD_INIT;
            HDR_LENGTH:  w_hdr_byte = cgrg_pkg::CMD_LENGTH;
            HDR_LEN_HI:  w_hdr_byte = r_j_lines[15:8];
            HDR_LEN_LO:  w_hdr_byte = r_j_lines[7:0];
            HDR_BPL_CMD: w_hdr_byte = cgrg_pkg::CMD_BPL;
            HDR_BPL:     w_hdr_byte = r_j_bpl;
            default:     w_hdr_byte = cgrg_pkg::ESC_BYTE;
        endcase
    end

    assign s_ctl.clear = (r_ctl == C_GEN) && (r_phase == PH_SYNC);
    assign s_ctl.start = (r_ctl == C_GEN) && (r_phase == PH_LINE) && !r_solid;

    cgrg_bitser u_bitser (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (s_ctl),
        .i_dots  (r_j_dots),
        .i_minor (r_j_minor),
        .i_major (r_j_major),
        .o_stat  (s_stat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_dots  <= 11'd672;
            r_cfg_lines <= 16'd400;
            r_cfg_max   <= 16'd4000;
            r_cfg_minor <= 16'd25;
            r_cfg_major <= 16'd100;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HEAD_DOTS:  r_cfg_dots  <= i_cfg_data[cgrg_pkg::DOTS_W-1:0];
                REG_LINE_COUNT: r_cfg_lines <= i_cfg_data;
                REG_MAX_LINES:  r_cfg_max   <= i_cfg_data;
                REG_MINOR:      r_cfg_minor <= i_cfg_data;
                REG_MAJOR:      r_cfg_major <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl     <= C_WAIT;
            r_phase   <= PH_IDLE;
            r_hdr     <= '0;
            r_line    <= '0;
            r_bidx    <= '0;
            r_lmin    <= '0;
            r_lmaj    <= '0;
            r_solid   <= 1'b0;
            r_j_dots  <= '0;
            r_j_lines <= '0;
            r_j_bpl   <= '0;
            r_j_minor <= 16'd1;
            r_j_major <= 16'd1;
        end else begin
            case (r_ctl)
                C_WAIT: begin
                    if (w_in_acc) begin
                        if (i_start_req) begin
                            if (w_cfg_bad) begin
                                r_phase    <= PH_IDLE;
                                r_res_byte <= '0;
                                r_res_last <= 1'b1;
                                r_res_err  <= 1'b1;
                                r_ctl      <= C_PUT;
                            end else begin
                                r_j_dots  <= w_dots_clip;
                                r_j_bpl   <= w_dots_sum[cgrg_pkg::DOTS_W-1:3];
                                r_j_lines <= r_cfg_lines;
                                r_j_minor <= r_cfg_minor;
                                r_j_major <= r_cfg_major;
                                r_hdr     <= '0;
                                r_line    <= '0;
                                r_bidx    <= '0;
                                r_lmin    <= '0;
                                r_lmaj    <= '0;
                                r_solid   <= 1'b0;
                                r_phase   <= (cgrg_pkg::PREAMBLE_ESCAPES != '0) ?
                                             PH_PRE : PH_HDR;
                                r_ctl     <= C_GEN;
                            end
                        end else if (r_phase != PH_IDLE) begin
                            r_ctl <= C_GEN;
                        end
                    end
                end
                C_GEN: begin
                    r_res_err <= 1'b0;
                    case (r_phase)
                        PH_PRE: begin
                            r_res_byte <= cgrg_pkg::ESC_BYTE;
                            r_res_last <= 1'b0;
                            r_ctl      <= C_PUT;
                            if (r_hdr + 7'd1 >= cgrg_pkg::PREAMBLE_ESCAPES) begin
                                r_hdr   <= '0;
                                r_phase <= PH_HDR;
                            end else begin
                                r_hdr <= r_hdr + 7'd1;
                            end
                        end
                        PH_HDR: begin
                            r_res_byte <= w_hdr_byte;
                            r_res_last <= 1'b0;
                            r_ctl      <= C_PUT;
                            if (r_hdr == HDR_BPL) begin
                                r_hdr   <= '0;
                                r_phase <= PH_SYNC;
                            end else begin
                                r_hdr <= r_hdr + 7'd1;
                            end
                        end
                        PH_SYNC: begin
                            r_res_byte <= cgrg_pkg::SYN_BYTE;
                            r_res_last <= 1'b0;
                            r_ctl      <= C_PUT;
                            r_solid    <= (r_line < cgrg_pkg::BORDER_LINES) ||
                                          (r_lmin == '0) || (r_lmaj < cgrg_pkg::RULE_WIDTH);
                            r_bidx     <= '0;
                            if (r_j_bpl == '0) begin
                                r_line  <= w_line_inc[cgrg_pkg::CNT_W-1:0];
                                r_lmin  <= cgrg_pkg::step_mod(r_lmin, r_j_minor);
                                r_lmaj  <= cgrg_pkg::step_mod(r_lmaj, r_j_major);
                                r_phase <= w_line_end ? PH_TAIL0 : PH_SYNC;
                            end else begin
                                r_phase <= PH_LINE;
                            end
                        end
                        PH_LINE: begin
                            r_res_byte <= cgrg_pkg::SOLID_BYTE;
                            r_res_last <= 1'b0;
                            r_ctl      <= r_solid ? C_PUT : C_SER;
                            r_bidx     <= w_bidx_inc[cgrg_pkg::BPL_W-1:0];
                            if (w_bidx_inc >= {1'b0, r_j_bpl}) begin
                                r_line  <= w_line_inc[cgrg_pkg::CNT_W-1:0];
                                r_lmin  <= cgrg_pkg::step_mod(r_lmin, r_j_minor);
                                r_lmaj  <= cgrg_pkg::step_mod(r_lmaj, r_j_major);
                                r_phase <= w_line_end ? PH_TAIL0 : PH_SYNC;
                            end
                        end
                        PH_TAIL0: begin
                            r_res_byte <= cgrg_pkg::ESC_BYTE;
                            r_res_last <= 1'b0;
                            r_ctl      <= C_PUT;
                            r_phase    <= PH_TAIL1;
                        end
                        PH_TAIL1: begin
                            r_res_byte <= cgrg_pkg::CMD_END;
                            r_res_last <= 1'b1;
                            r_ctl      <= C_PUT;
                            r_phase    <= PH_IDLE;
                        end
                        default: begin
                            r_phase <= PH_IDLE;
                            r_ctl   <= C_WAIT;
                        end
                    endcase
                end
                C_SER: begin
                    if (s_stat.done) begin
                        r_res_byte <= s_stat.data;
                        r_ctl      <= C_PUT;
                    end
                end
                C_PUT: begin
                    if (w_out_free) begin
                        r_ctl <= C_WAIT;
                    end
                end
                default: r_ctl <= C_WAIT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_ctl == C_PUT && w_out_free) begin
            r_out_valid <= 1'b1;
            r_out_byte  <= r_res_byte;
            r_out_last  <= r_res_last;
            r_out_err   <= r_res_err;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_data_byte = r_out_byte;
    assign o_last      = r_out_last;
    assign o_error     = r_out_err;

    a_err_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_error) |-> o_last)
        else $error("error beat without last");

    a_ser_done_in_ser: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_stat.done |-> (r_ctl == C_SER))
        else $error("serialiser finished outside its wait");

    a_ser_not_solid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ctl == C_SER) |-> !r_solid)
        else $error("serialiser running on a solid line");

    a_hdr_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HDR) |-> (r_hdr <= HDR_BPL))
        else $error("header index out of range");

    a_line_bpl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LINE) |-> (r_j_bpl != '0))
        else $error("pattern phase with empty line");

endmodule

[tb/testbench.sv]
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LEAD_ESCAPES = 100;
    localparam logic [7:0]  B_ESC        = 8'h1B;
    localparam logic [7:0]  B_SYN        = 8'h16;
    localparam logic [7:0]  B_INIT       = 8'h40;
    localparam logic [7:0]  B_LENGTH     = 8'h4C;
    localparam logic [7:0]  B_BPL        = 8'h44;
    localparam logic [7:0]  B_END        = 8'h45;
    localparam logic [7:0]  B_SOLID      = 8'hFF;
    localparam logic [10:0] WIDEST_HEAD  = 11'd2040;
    localparam int SETTLE_CYCLES = 16;
    localparam int STALL_LIMIT   = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int RANDOM_BEATS  = 300;

    typedef enum logic [2:0] {
        REG_HEAD_DOTS  = 3'd0,
        REG_LINE_COUNT = 3'd1,
        REG_MAX_LINES  = 3'd2,
        REG_MINOR      = 3'd3,
        REG_MAJOR      = 3'd4
    } reg_idx_e;

    typedef enum logic [2:0] {
        JOB_IDLE, JOB_LEAD, JOB_HEADER, JOB_SYNC, JOB_PIXELS, JOB_TAIL_ESC, JOB_TAIL_END
    } job_phase_e;

    typedef struct packed {
        logic start;
        logic wait_drain;
    } request_t;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       err;
    } job_byte_t;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_in_valid  = 1'b0;
    logic        i_start_req = 1'b0;
    logic        i_out_stall = 1'b0;
    logic        i_cfg_valid = 1'b0;
    logic [2:0]  i_cfg_index = REG_HEAD_DOTS;
    logic [15:0] i_cfg_data  = 16'd0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [7:0]  o_data_byte;
    logic        o_last;
    logic        o_error;
    logic        o_cfg_ready;

    calibration_grid_raster_gen uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_start_req (i_start_req),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_data_byte (o_data_byte),
        .o_last      (o_last),
        .o_error     (o_error),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    request_t  req_q[$];
    job_byte_t grid_q[$];
    bit        in_beat     = 1'b0;
    bit        calm        = 1'b0;
    int        hold_asks   = 0;
    int        holds_done  = 0;
    int        hold_left   = 0;
    int        mismatches  = 0;
    int        beat_count  = 0;
    int        quiet_count = 0;

    logic [10:0] reg_head  = 11'd672;
    logic [15:0] reg_lines = 16'd400;
    logic [15:0] reg_max   = 16'd4000;
    logic [15:0] reg_minor = 16'd25;
    logic [15:0] reg_major = 16'd100;

    job_phase_e  job_phase     = JOB_IDLE;
    logic [6:0]  hdr_pos       = '0;
    logic [15:0] row           = '0;
    logic [7:0]  col_byte      = '0;
    logic [15:0] row_mod_minor = '0;
    logic [15:0] row_mod_major = '0;
    logic [15:0] col_mod_minor = '0;
    logic [15:0] col_mod_major = '0;
    logic        row_solid     = 1'b0;
    logic [10:0] job_dots      = '0;
    logic [15:0] job_rows      = '0;
    logic [7:0]  job_bpl       = '0;
    logic [15:0] job_minor     = 16'd1;
    logic [15:0] job_major     = 16'd1;

    function automatic logic [15:0] next_mod(input logic [15:0] cnt, input logic [15:0] modulus);
        if ({1'b0, cnt} + 17'd1 >= {1'b0, modulus})
            return 16'd0;
        return cnt + 16'd1;
    endfunction

    function automatic int job_beats(input int dots, input int rows);
        int d;
        d = (dots > 2040) ? 2040 : dots;
        return LEAD_ESCAPES + 9 + rows * (1 + (d + 7) / 8) + 2;
    endfunction

    task automatic end_row();
        row           = row + 16'd1;
        row_mod_minor = next_mod(row_mod_minor, job_minor);
        row_mod_major = next_mod(row_mod_major, job_major);
        job_phase     = (row >= job_rows) ? JOB_TAIL_ESC : JOB_SYNC;
    endtask

    task automatic step_grid(input logic start, output bit produced, output job_byte_t beat);
        logic [7:0]  pat;
        logic [11:0] x;
        bit          faulty;
        produced = 1'b1;
        beat     = '{8'h00, 1'b0, 1'b0};
        faulty   = 1'b0;
        if (start) begin
            if (reg_lines == 16'd0 || reg_lines > reg_max || reg_minor == 16'd0 ||
                reg_major == 16'd0) begin
                faulty    = 1'b1;
                job_phase = JOB_IDLE;
                beat      = '{8'h00, 1'b1, 1'b1};
            end else begin
                job_dots      = (reg_head > WIDEST_HEAD) ? WIDEST_HEAD : reg_head;
                job_bpl       = 8'(({1'b0, job_dots} + 12'd7) >> 3);
                job_rows      = reg_lines;
                job_minor     = reg_minor;
                job_major     = reg_major;
                hdr_pos       = '0;
                row           = '0;
                col_byte      = '0;
                row_mod_minor = '0;
                row_mod_major = '0;
                col_mod_minor = '0;
                col_mod_major = '0;
                row_solid     = 1'b0;
                job_phase     = JOB_LEAD;
            end
        end
        if (!faulty) begin
            case (job_phase)
                JOB_LEAD: begin
                    beat.data = B_ESC;
                    hdr_pos   = hdr_pos + 7'd1;
                    if (hdr_pos >= LEAD_ESCAPES) begin
                        hdr_pos   = '0;
                        job_phase = JOB_HEADER;
                    end
                end
                JOB_HEADER: begin
                    case (hdr_pos)
                        7'd1:    beat.data = B_INIT;
                        7'd3:    beat.data = B_LENGTH;
                        7'd4:    beat.data = job_rows[15:8];
                        7'd5:    beat.data = job_rows[7:0];
                        7'd7:    beat.data = B_BPL;
                        7'd8:    beat.data = job_bpl;
                        default: beat.data = B_ESC;
                    endcase
                    hdr_pos = hdr_pos + 7'd1;
                    if (hdr_pos > 7'd8) begin
                        hdr_pos   = '0;
                        job_phase = JOB_SYNC;
                    end
                end
                JOB_SYNC: begin
                    beat.data     = B_SYN;
                    row_solid     = (row < 16'd4) || (row_mod_minor == 16'd0) ||
                                    (row_mod_major < 16'd3);
                    col_byte      = '0;
                    col_mod_minor = '0;
                    col_mod_major = '0;
                    if (job_bpl == 8'd0)
                        end_row();
                    else
                        job_phase = JOB_PIXELS;
                end
                JOB_PIXELS: begin
                    if (row_solid) begin
                        beat.data = B_SOLID;
                    end else begin
                        pat = 8'h00;
                        for (int k = 0; k < 8; k++) begin
                            x = {1'b0, col_byte, 3'b000} + 12'(k);
                            if (x < {1'b0, job_dots} && (x < 12'd4 || col_mod_minor == 16'd0 ||
                                                         col_mod_major < 16'd3))
                                pat = pat | (8'h80 >> k);
                            col_mod_minor = next_mod(col_mod_minor, job_minor);
                            col_mod_major = next_mod(col_mod_major, job_major);
                        end
                        beat.data = pat;
                    end
                    col_byte = col_byte + 8'd1;
                    if (col_byte >= job_bpl)
                        end_row();
                end
                JOB_TAIL_ESC: begin
                    beat.data = B_ESC;
                    job_phase = JOB_TAIL_END;
                end
                JOB_TAIL_END: begin
                    beat.data = B_END;
                    beat.last = 1'b1;
                    job_phase = JOB_IDLE;
                end
                default: begin
                    produced  = 1'b0;
                    job_phase = JOB_IDLE;
                end
            endcase
        end
    endtask

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("beat %0d: %s is %0h, expected %0h", beat_count, what, got, want);
        mismatches++;
    endtask

    always @(posedge i_clk) begin : monitor
        bit        produced;
        job_byte_t beat;
        job_byte_t want;
        in_beat = i_in_valid && !o_in_stall;
        if (i_rst_n) begin
            if (in_beat) begin
                step_grid(i_start_req, produced, beat);
                if (produced)
                    grid_q.push_back(beat);
            end
            if (o_out_valid && !i_out_stall) begin
                if (grid_q.size() == 0) begin
                    report_mismatch("unexpected beat, data", o_data_byte, 0);
                end else begin
                    want = grid_q.pop_front();
                    if (o_data_byte !== want.data)
                        report_mismatch("data_byte", o_data_byte, want.data);
                    if (o_last !== want.last)
                        report_mismatch("last", o_last, want.last);
                    if (o_error !== want.err)
                        report_mismatch("error", o_error, want.err);
                end
                beat_count++;
            end
            if (in_beat || (o_out_valid && !i_out_stall) || (i_cfg_valid && o_cfg_ready))
                quiet_count = 0;
            else
                quiet_count++;
            if (quiet_count >= STALL_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    always @(negedge i_clk) begin : feeder
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (in_beat)
                void'(req_q.pop_front());
            if (i_in_valid && !in_beat) begin
                // hold the stalled beat
            end else if (req_q.size() > 0 && !(req_q[0].wait_drain && grid_q.size() > 0) &&
                         (calm || $urandom_range(99) >= 18)) begin
                i_in_valid  <= 1'b1;
                i_start_req <= req_q[0].start;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin : sink
        if (hold_asks != holds_done) begin
            holds_done = hold_asks;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 18);
        end
    end

    task automatic write_reg(input reg_idx_e idx, input logic [15:0] val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready)
            @(posedge i_clk);
        case (idx)
            REG_HEAD_DOTS:  reg_head  = val[10:0];
            REG_LINE_COUNT: reg_lines = val;
            REG_MAX_LINES:  reg_max   = val;
            REG_MINOR:      reg_minor = val;
            REG_MAJOR:      reg_major = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic program_grid(input int dots, input int rows, input int maxl,
                                input int minor, input int major);
        write_reg(REG_HEAD_DOTS, 16'(dots));
        write_reg(REG_LINE_COUNT, 16'(rows));
        write_reg(REG_MAX_LINES, 16'(maxl));
        write_reg(REG_MINOR, 16'(minor));
        write_reg(REG_MAJOR, 16'(major));
    endtask

    task automatic queue_run(input int beats, input int drain_at);
        request_t r;
        for (int n = 0; n < beats; n++) begin
            r.start      = (n == 0);
            r.wait_drain = (n == drain_at);
            req_q.push_back(r);
        end
    endtask

    task automatic queue_idle(input int count);
        for (int n = 0; n < count; n++)
            req_q.push_back('{1'b0, 1'b0});
    endtask

    task automatic settle();
        while (req_q.size() != 0 || grid_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    initial begin : scenario
        int rand_beats;
        int dots;
        int rows;
        int maxl;
        int minor;
        int major;
        int beats;
        int cut;
        int shape;
        int count;
        request_t r;

        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // idle requests, then the reset settings with a restart mid job
        queue_idle(2);
        queue_run(140, -1);
        queue_run(60, -1);
        settle();

        // invalid settings: no lines, too many lines, zero spacings
        program_grid(8, 0, 10, 3, 5);
        queue_run(1, -1);
        queue_idle(1);
        settle();
        program_grid(8, 11, 10, 3, 5);
        queue_run(1, -1);
        queue_idle(1);
        settle();
        program_grid(8, 4, 10, 0, 5);
        queue_run(1, -1);
        queue_idle(1);
        settle();
        program_grid(8, 4, 10, 3, 0);
        queue_run(1, -1);
        queue_idle(1);
        settle();

        // zero head, line count equal to the limit
        program_grid(0, 1, 1, 1, 1);
        queue_run(job_beats(0, 1), -1);
        queue_idle(2);
        settle();

        // padded lines; long receiver hold-off, then a drain pause mid job
        program_grid(13, 9, 9, 3, 5);
        queue_run(job_beats(13, 9), 60);
        hold_asks++;
        settle();

        // widest head with upper data bits set, full-scale header, abandoned
        program_grid(16'hFFFF, 65535, 65535, 65535, 65535);
        queue_run(115, -1);
        settle();

        // widest head, one full solid line, no idling
        program_grid(2047, 1, 65535, 65535, 65535);
        calm = 1'b1;
        queue_run(job_beats(2047, 1), -1);
        settle();
        calm = 1'b0;

        rand_beats = 0;
        while (rand_beats < RANDOM_BEATS) begin
            shape = $urandom_range(99);
            if (shape < 75)
                dots = $urandom_range(0, 24);
            else if (shape < 95)
                dots = $urandom_range(25, 200);
            else
                dots = $urandom_range(201, 2047);
            rows  = (dots > 200) ? $urandom_range(1, 2) : $urandom_range(1, 12);
            maxl  = ($urandom_range(2) == 0) ? rows + $urandom_range(0, 20) : 65535;
            minor = ($urandom_range(9) < 8) ? $urandom_range(1, 9) : $urandom_range(10, 65535);
            major = ($urandom_range(9) < 8) ? $urandom_range(1, 12) : $urandom_range(13, 65535);
            if ($urandom_range(7) == 0) begin
                case ($urandom_range(3))
                    0: rows = 0;
                    1: begin
                        rows = $urandom_range(2, 12);
                        maxl = $urandom_range(1, rows - 1);
                    end
                    2: minor = 0;
                    default: major = 0;
                endcase
                program_grid(dots, rows, maxl, minor, major);
                queue_run(1, -1);
                queue_idle($urandom_range(0, 2));
                rand_beats += 1;
            end else begin
                program_grid(dots, rows, maxl, minor, major);
                beats = job_beats(dots, rows);
                shape = $urandom_range(99);
                if (shape < 75) begin
                    queue_run(beats, -1);
                    queue_idle($urandom_range(0, 3));
                    rand_beats += beats;
                end else if (shape < 90) begin
                    cut = $urandom_range(1, beats - 1);
                    queue_run(cut, -1);
                    queue_run(beats, -1);
                    rand_beats += cut + beats;
                end else begin
                    count = $urandom_range(5, 40);
                    for (int n = 0; n < count; n++) begin
                        r.start      = ($urandom_range(15) == 0);
                        r.wait_drain = 1'b0;
                        req_q.push_back(r);
                    end
                    rand_beats += count;
                end
            end
            settle();
        end

        if (mismatches == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
